FILE: hw/rtl/strand_edge_stretch_force_unit_macros.svh
// Assertion shorthands shared by the RTL; clk and rst_n are taken from the enclosing module.
`ifndef STRAND_EDGE_STRETCH_FORCE_UNIT_MACROS_SVH
`define STRAND_EDGE_STRETCH_FORCE_UNIT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define SESF_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define SESF_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

FILE: hw/rtl/sesf_pkg.sv
package sesf_pkg;

  localparam int LEN_W = 31;
  localparam int T_W   = 18;
  localparam int FRAC  = 16;
  localparam int Q_W   = 47;
  localparam int KS_W  = 46;
  localparam int TM_W  = 18;
  localparam int DM_W  = 48;
  localparam int O_W   = 35;
  localparam int E_W   = 36;
  localparam int M_W   = 62;

  localparam logic [M_W-1:0] QCAP  = {M_W{1'b1}};
  localparam logic [Q_W-1:0] Q_ONE = 47'd65536;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRETCH_MULT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXACT_JAC    = 1'b1;

  typedef struct packed {
    logic [KS_W-1:0]            ks;
    logic [LEN_W-1:0]           r;
    logic [LEN_W-1:0]           l;
    logic [2:0]                 tneg;
    logic [2:0][TM_W-1:0]       tm;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

FILE: hw/rtl/strand_edge_stretch_force_unit.sv
// Channel   Handshake               Payload
// in_       in_valid / in_stall     stiffness, rest and current length, unit tangent
// out_      out_valid / out_stall   force, six Jacobian entries, energy
// cfg_      cfg_valid / cfg_ready   cfg_index, cfg_wdata (ready is always high)
//
// One word is accepted and one delivered per cycle, sustained while out_stall is low.
// Each word passes the front register, the queue, 47 divider stages, one preparation stage,
// three two-stage products and the output register, mostly the bit-per-stage dividers.
// Synchronous reset clears the valid bits and loads the register defaults; no clearing pass.
// out_stall freezes the back pipeline; the four-word queue lets the front accept until full.
module strand_edge_stretch_force_unit
  import sesf_pkg::*;
#(
  parameter int FIFO_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [LEN_W-1:0]     in_stiffness,
  input  logic [LEN_W-1:0]     in_rest_length,
  input  logic [LEN_W-1:0]     in_current_length,
  input  logic signed [T_W-1:0] in_tangent_x,
  input  logic signed [T_W-1:0] in_tangent_y,
  input  logic signed [T_W-1:0] in_tangent_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_force_x,
  output logic signed [31:0]   out_force_y,
  output logic signed [31:0]   out_force_z,
  output logic signed [31:0]   out_jac_xx,
  output logic signed [31:0]   out_jac_xy,
  output logic signed [31:0]   out_jac_xz,
  output logic signed [31:0]   out_jac_yy,
  output logic signed [31:0]   out_jac_yz,
  output logic signed [31:0]   out_jac_zz,
  output logic [LEN_W-1:0]     out_energy,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_wdata
);

  logic [LEN_W-1:0] mult_r, mult_nxt;
  logic             exact_r, exact_nxt;
  logic             push, pop;
  item_t            push_item, head_item;
  fifo_stat_t       stat;
  logic [2:0][31:0] force_w;
  logic [5:0][31:0] jac_w;

  assign cfg_ready = 1'b1;

  always_comb begin
    mult_nxt  = mult_r;
    exact_nxt = exact_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STRETCH_MULT: mult_nxt  = cfg_wdata;
        CFG_EXACT_JAC:    exact_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r  <= LEN_W'(65536);
      exact_r <= 1'b0;
    end else begin
      mult_r  <= mult_nxt;
      exact_r <= exact_nxt;
    end
  end

  sesf_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_stiffness(in_stiffness), .in_rest_length(in_rest_length),
    .in_current_length(in_current_length),
    .in_tangent_x(in_tangent_x), .in_tangent_y(in_tangent_y), .in_tangent_z(in_tangent_z),
    .mult_i(mult_r), .stat_i(stat), .push_o(push), .item_o(push_item)
  );

  sesf_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push_i(push), .wdata_i(push_item), .pop_i(pop), .rdata_o(head_item), .stat_o(stat)
  );

  sesf_back u_back (
    .clk(clk), .rst_n(rst_n), .exact_i(exact_r),
    .head_i(head_item), .stat_i(stat), .pop_o(pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .force_o(force_w), .jac_o(jac_w), .energy_o(out_energy)
  );

  assign out_force_x = force_w[0];
  assign out_force_y = force_w[1];
  assign out_force_z = force_w[2];
  assign out_jac_xx  = jac_w[0];
  assign out_jac_xy  = jac_w[1];
  assign out_jac_xz  = jac_w[2];
  assign out_jac_yy  = jac_w[3];
  assign out_jac_yz  = jac_w[4];
  assign out_jac_zz  = jac_w[5];

endmodule

FILE: hw/rtl/sesf_div.sv
module sesf_div
  import sesf_pkg::*;
#(
  parameter int NW = 47,
  parameter int DW = 31
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quo_o
);

  // One quotient bit per stage; the numerator register fills with quotient bits from the right.
  logic [NW-1:0] num_r [NW];
  logic [DW-1:0] rem_r [NW];
  logic [DW-1:0] den_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [NW-1:0] num_in;
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_sub;
    logic          ge;

    if (k == 0) begin : g_first
      assign num_in = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign num_in = num_r[k-1];
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
    end

    assign rem_sh  = {rem_in, num_in[NW-1]};
    assign ge      = rem_sh >= {1'b0, den_in};
    assign rem_sub = rem_sh - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k] <= {num_in[NW-2:0], ge};
        rem_r[k] <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        den_r[k] <= den_in;
      end
    end
  end

  assign quo_o = num_r[NW-1];

endmodule

FILE: hw/rtl/sesf_mulq.sv
module sesf_mulq
  import sesf_pkg::*;
(
  input  logic           clk,
  input  logic           en,
  input  logic [M_W-1:0] a_i,
  input  logic [M_W-1:0] b_i,
  output logic [M_W-1:0] p_o
);

  localparam int H = M_W / 2;

  logic [M_W-1:0]   pll_r, plh_r, phl_r, phh_r;
  logic             both_hi_r;
  logic [2*M_W-1:0] sum;
  logic [2*M_W-FRAC-1:0] sh;
  logic [M_W-1:0]   p_r;

  // Both operands at or above 2^32 give the cap outright, whatever the product.
  always_ff @(posedge clk) begin
    if (en) begin
      pll_r     <= a_i[H-1:0] * b_i[H-1:0];
      plh_r     <= a_i[H-1:0] * b_i[M_W-1:H];
      phl_r     <= a_i[M_W-1:H] * b_i[H-1:0];
      phh_r     <= a_i[M_W-1:H] * b_i[M_W-1:H];
      both_hi_r <= (|a_i[M_W-1:32]) && (|b_i[M_W-1:32]);
    end
  end

  assign sum = ((2*M_W)'(phh_r) << M_W)
             + (((2*M_W)'(plh_r) + (2*M_W)'(phl_r)) << H)
             + (2*M_W)'(pll_r);
  assign sh  = sum[2*M_W-1:FRAC];

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= (both_hi_r || (|sh[2*M_W-FRAC-1:M_W])) ? QCAP : sh[M_W-1:0];
    end
  end

  assign p_o = p_r;

endmodule

FILE: hw/rtl/sesf_fifo.sv
`include "strand_edge_stretch_force_unit_macros.svh"

module sesf_fifo
  import sesf_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_i,
  input  item_t      wdata_i,
  input  logic       pop_i,
  output item_t      rdata_o,
  output fifo_stat_t stat_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  item_t         mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= wdata_i;
    end
  end

  assign rdata_o      = mem_r[rd_ptr_r];
  assign stat_o.full  = (cnt_r == FULL_CNT);
  assign stat_o.empty = (cnt_r == '0);

  `SESF_ASSERT(a_cnt_bound, cnt_r <= FULL_CNT, "queue count exceeds its depth")
  `SESF_ASSERT(a_no_overflow, !(push_i && stat_o.full), "word pushed into a full queue")
  `SESF_ASSERT(a_no_underflow, !(pop_i && stat_o.empty), "word popped from an empty queue")
  `SESF_ASSERT_NEXT(a_push_fills, push_i && !pop_i, cnt_r != '0, "queue empty after a push")

endmodule

FILE: hw/rtl/sesf_front.sv
module sesf_front
  import sesf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [LEN_W-1:0] in_stiffness,
  input  logic [LEN_W-1:0] in_rest_length,
  input  logic [LEN_W-1:0] in_current_length,
  input  logic [T_W-1:0]   in_tangent_x,
  input  logic [T_W-1:0]   in_tangent_y,
  input  logic [T_W-1:0]   in_tangent_z,
  input  logic [LEN_W-1:0] mult_i,
  input  fifo_stat_t       stat_i,
  output logic             push_o,
  output item_t            item_o
);

  logic              v_r, v_nxt;
  item_t             item_r;
  item_t             item_nxt;
  logic              adv;
  logic [M_W-1:0]    prod;
  logic [2:0][T_W-1:0] t;

  assign adv      = !v_r || !stat_i.full;
  assign in_stall = !adv;
  assign push_o   = v_r && !stat_i.full;
  assign item_o   = item_r;

  assign t[0] = in_tangent_x;
  assign t[1] = in_tangent_y;
  assign t[2] = in_tangent_z;

  assign prod = M_W'(in_stiffness) * M_W'(mult_i);

  // A zero length is taken as the smallest positive raw value.
  always_comb begin
    item_nxt.ks = prod[M_W-1:FRAC];
    item_nxt.r  = (in_rest_length == '0) ? LEN_W'(1) : in_rest_length;
    item_nxt.l  = (in_current_length == '0) ? LEN_W'(1) : in_current_length;
    for (int i = 0; i < 3; i++) begin
      item_nxt.tneg[i] = t[i][T_W-1];
      item_nxt.tm[i]   = t[i][T_W-1] ? TM_W'(~t[i] + 1'b1) : TM_W'(t[i]);
    end
    v_nxt = adv ? in_valid : v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

endmodule

FILE: hw/rtl/sesf_back.sv
module sesf_back
  import sesf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 exact_i,
  input  item_t                head_i,
  input  fifo_stat_t           stat_i,
  output logic                 pop_o,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0][31:0]     force_o,
  output logic [5:0][31:0]     jac_o,
  output logic [LEN_W-1:0]     energy_o
);

  localparam int VLAT = Q_W + 7;
  localparam int PI [6] = '{0, 0, 0, 1, 1, 2};
  localparam int PJ [6] = '{0, 1, 2, 1, 2, 2};

  typedef struct packed {
    logic [KS_W-1:0]      ks;
    logic [LEN_W-1:0]     r;
    logic [DM_W-1:0]      dm;
    logic                 dneg;
    logic [2:0]           tneg;
    logic [2:0][TM_W-1:0] tm;
    logic [5:0][E_W-1:0]  emag;
    logic [5:0]           eneg;
  } prep_t;

  typedef struct packed {
    logic [KS_W-1:0]  ks;
    logic [LEN_W-1:0] r;
    logic [2:0]       fneg;
    logic [5:0]       jneg;
  } l1s_t;

  typedef struct packed {
    logic [LEN_W-1:0]     r;
    logic [2:0]           fneg;
    logic [5:0]           jneg;
    logic [5:0][M_W-1:0]  jm;
  } l2s_t;

  typedef struct packed {
    logic [2:0][M_W-1:0]  fm;
    logic [2:0]           fneg;
    logic [5:0]           jneg;
    logic [5:0][M_W-1:0]  jm;
  } l3s_t;

  function automatic logic [31:0] sat32(input logic neg, input logic [M_W-1:0] mag);
    logic [31:0] res;
    if (mag == '0) begin
      res = '0;
    end else if (neg) begin
      res = (mag >= M_W'(32'h8000_0000)) ? 32'h8000_0000 : (~mag[31:0] + 1'b1);
    end else begin
      res = (mag >= M_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mag[31:0];
    end
    return res;
  endfunction

  logic                en;
  logic [VLAT-1:0]     vld_r;
  item_t               side_r [Q_W];
  prep_t               prep_r, prep_nxt;
  l1s_t                l1s_r [2];
  l2s_t                l2s_r [2];
  l3s_t                l3s_r [2];
  logic                out_valid_r;
  logic [2:0][31:0]    force_r;
  logic [5:0][31:0]    jac_r;
  logic [LEN_W-1:0]    energy_r;

  logic [Q_W-1:0]      q_quo, ir_quo, il_quo;
  logic [5:0][Q_W-1:0] o_quo;
  logic [2:0][M_W-1:0] mdt, fm;
  logic [5:0][M_W-1:0] jm;
  logic [M_W-1:0]      dd, kd, en_prod;

  // The whole back pipeline moves together and freezes while a finished word waits.
  assign en    = !out_valid_r || !out_stall;
  assign pop_o = en && !stat_i.empty;

  sesf_div #(.NW(Q_W), .DW(LEN_W)) u_div_q (
    .clk(clk), .en(en), .num_i({head_i.l, 16'b0}), .den_i(head_i.r), .quo_o(q_quo)
  );
  sesf_div #(.NW(Q_W), .DW(LEN_W)) u_div_ir (
    .clk(clk), .en(en), .num_i(Q_W'(1) << 32), .den_i(head_i.r), .quo_o(ir_quo)
  );
  sesf_div #(.NW(Q_W), .DW(LEN_W)) u_div_il (
    .clk(clk), .en(en), .num_i(Q_W'(1) << 32), .den_i(head_i.l), .quo_o(il_quo)
  );

  for (genvar p = 0; p < 6; p++) begin : g_odiv
    logic [2*TM_W-1:0] tt;
    assign tt = head_i.tm[PI[p]] * head_i.tm[PJ[p]];
    sesf_div #(.NW(Q_W), .DW(LEN_W)) u_div_o (
      .clk(clk), .en(en), .num_i(Q_W'(tt)), .den_i(head_i.r), .quo_o(o_quo[p])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[VLAT-2:0], !stat_i.empty};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= head_i;
      for (int k = 1; k < Q_W; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Strain offset, identity term and the tangent products combined into signed magnitudes.
  always_comb begin
    logic [Q_W:0]   qx;
    logic signed [33:0] a;
    logic signed [E_W:0] e;
    item_t s;
    s  = side_r[Q_W-1];
    qx = {1'b0, q_quo};
    a  = $signed({1'b0, ir_quo[32:0]}) - $signed({1'b0, il_quo[32:0]});
    if (!exact_i && a[33]) begin
      a = '0;
    end
    prep_nxt.ks   = s.ks;
    prep_nxt.r    = s.r;
    prep_nxt.tneg = s.tneg;
    prep_nxt.tm   = s.tm;
    prep_nxt.dneg = q_quo < Q_ONE;
    prep_nxt.dm   = prep_nxt.dneg ? DM_W'({1'b0, Q_ONE} - qx) : DM_W'(qx - {1'b0, Q_ONE});
    for (int p = 0; p < 6; p++) begin
      if (PI[p] == PJ[p]) begin
        e = $signed({2'b0, o_quo[p][O_W-1:0]}) + (E_W+1)'(a);
        prep_nxt.eneg[p] = e[E_W];
        prep_nxt.emag[p] = e[E_W] ? E_W'(-e) : E_W'(e);
      end else begin
        prep_nxt.eneg[p] = s.tneg[PI[p]] ^ s.tneg[PJ[p]];
        prep_nxt.emag[p] = E_W'(o_quo[p][O_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_r <= prep_nxt;
    end
  end

  // First product layer: strain times tangent, strain squared and the Jacobian entries.
  for (genvar i = 0; i < 3; i++) begin : g_mdt
    sesf_mulq u_mul (
      .clk(clk), .en(en), .a_i(M_W'(prep_r.dm)), .b_i(M_W'(prep_r.tm[i])), .p_o(mdt[i])
    );
  end
  sesf_mulq u_mul_dd (
    .clk(clk), .en(en), .a_i(M_W'(prep_r.dm)), .b_i(M_W'(prep_r.dm)), .p_o(dd)
  );
  for (genvar p = 0; p < 6; p++) begin : g_jac
    sesf_mulq u_mul (
      .clk(clk), .en(en), .a_i(M_W'(prep_r.ks)), .b_i(M_W'(prep_r.emag[p])), .p_o(jm[p])
    );
  end

  // Second layer: forces and stiffness times strain squared.
  for (genvar i = 0; i < 3; i++) begin : g_force
    sesf_mulq u_mul (
      .clk(clk), .en(en), .a_i(M_W'(l1s_r[1].ks)), .b_i(mdt[i]), .p_o(fm[i])
    );
  end
  sesf_mulq u_mul_kd (
    .clk(clk), .en(en), .a_i(M_W'(l1s_r[1].ks)), .b_i(dd), .p_o(kd)
  );

  // Third layer: energy before halving.
  sesf_mulq u_mul_en (
    .clk(clk), .en(en), .a_i(kd), .b_i(M_W'(l2s_r[1].r)), .p_o(en_prod)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      l1s_r[0].ks   <= prep_r.ks;
      l1s_r[0].r    <= prep_r.r;
      l1s_r[0].fneg <= prep_r.tneg ^ {3{prep_r.dneg}};
      l1s_r[0].jneg <= prep_r.eneg;
      l1s_r[1]      <= l1s_r[0];

      l2s_r[0].r    <= l1s_r[1].r;
      l2s_r[0].fneg <= l1s_r[1].fneg;
      l2s_r[0].jneg <= l1s_r[1].jneg;
      l2s_r[0].jm   <= jm;
      l2s_r[1]      <= l2s_r[0];

      l3s_r[0].fm   <= fm;
      l3s_r[0].fneg <= l2s_r[1].fneg;
      l3s_r[0].jneg <= l2s_r[1].jneg;
      l3s_r[0].jm   <= l2s_r[1].jm;
      l3s_r[1]      <= l3s_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[VLAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        force_r[i] <= sat32(l3s_r[1].fneg[i], l3s_r[1].fm[i]);
      end
      for (int p = 0; p < 6; p++) begin
        jac_r[p] <= sat32(l3s_r[1].jneg[p], l3s_r[1].jm[p]);
      end
      energy_r <= (|en_prod[M_W-1:32]) ? {LEN_W{1'b1}} : en_prod[31:1];
    end
  end

  assign out_valid = out_valid_r;
  assign force_o   = force_r;
  assign jac_o     = jac_r;
  assign energy_o  = energy_r;

endmodule
